// ----- rtl/mtd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtd_pkg
// Shared types, result codes, register indexes and the Morse code table.
// ----------------------------------------------------------------------------
package mtd_pkg;

    localparam int LEVEL_W       = 12;
    localparam int CFG_TICK_W    = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 3;
    localparam int KIND_W        = 2;
    localparam int CHAR_W        = 7;
    localparam int PATTERN_BITS  = 7;
    localparam int TABLE_MAX_LEN = 5;
    localparam int TABLE_LEN_W   = 3;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 8;

    localparam logic [KIND_W-1:0] KIND_CHAR     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WORD_END = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_THRESHOLD  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DOT_LIMIT_TICKS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DASH_LIMIT_TICKS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_GAP_TICKS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WORD_GAP_TICKS   = 3'd4;

    localparam logic [LEVEL_W-1:0]    LEVEL_THRESHOLD_RST  = 12'd200;
    localparam logic [CFG_TICK_W-1:0] DOT_LIMIT_TICKS_RST  = 16'd10;
    localparam logic [CFG_TICK_W-1:0] DASH_LIMIT_TICKS_RST = 16'd28;
    localparam logic [CFG_TICK_W-1:0] SYMBOL_GAP_TICKS_RST = 16'd7;
    localparam logic [CFG_TICK_W-1:0] WORD_GAP_TICKS_RST   = 16'd44;

    typedef struct packed {
        logic [LEVEL_W-1:0]    level_threshold;
        logic [CFG_TICK_W-1:0] dot_limit_ticks;
        logic [CFG_TICK_W-1:0] dash_limit_ticks;
        logic [CFG_TICK_W-1:0] symbol_gap_ticks;
        logic [CFG_TICK_W-1:0] word_gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] char_out;
        logic              last;
    } result_t;

    typedef struct packed {
        result_t r0;
        result_t r1;
    } result_pair_t;

    // pattern: first symbol in bit 0, dash = 1; returns 0 when no entry matches
    function automatic logic [CHAR_W-1:0] morse_lookup(
        input logic [TABLE_LEN_W-1:0]  len,
        input logic [PATTERN_BITS-1:0] pat
    );
        logic [CHAR_W-1:0] ch;
        unique case ({len, pat})
            {3'd2, 7'd2}:  ch = 7'h41;
            {3'd4, 7'd1}:  ch = 7'h42;
            {3'd4, 7'd5}:  ch = 7'h43;
            {3'd3, 7'd1}:  ch = 7'h44;
            {3'd1, 7'd0}:  ch = 7'h45;
            {3'd4, 7'd4}:  ch = 7'h46;
            {3'd3, 7'd3}:  ch = 7'h47;
            {3'd4, 7'd0}:  ch = 7'h48;
            {3'd2, 7'd0}:  ch = 7'h49;
            {3'd4, 7'd14}: ch = 7'h4A;
            {3'd3, 7'd5}:  ch = 7'h4B;
            {3'd4, 7'd2}:  ch = 7'h4C;
            {3'd2, 7'd3}:  ch = 7'h4D;
            {3'd2, 7'd1}:  ch = 7'h4E;
            {3'd3, 7'd7}:  ch = 7'h4F;
            {3'd4, 7'd6}:  ch = 7'h50;
            {3'd4, 7'd11}: ch = 7'h51;
            {3'd3, 7'd2}:  ch = 7'h52;
            {3'd3, 7'd0}:  ch = 7'h53;
            {3'd1, 7'd1}:  ch = 7'h54;
            {3'd3, 7'd4}:  ch = 7'h55;
            {3'd4, 7'd8}:  ch = 7'h56;
            {3'd3, 7'd6}:  ch = 7'h57;
            {3'd4, 7'd9}:  ch = 7'h58;
            {3'd4, 7'd13}: ch = 7'h59;
            {3'd4, 7'd3}:  ch = 7'h5A;
            {3'd5, 7'd30}: ch = 7'h31;
            {3'd5, 7'd28}: ch = 7'h32;
            {3'd5, 7'd24}: ch = 7'h33;
            {3'd5, 7'd16}: ch = 7'h34;
            {3'd5, 7'd0}:  ch = 7'h35;
            {3'd5, 7'd1}:  ch = 7'h36;
            {3'd5, 7'd3}:  ch = 7'h37;
            {3'd5, 7'd7}:  ch = 7'h38;
            {3'd5, 7'd15}: ch = 7'h39;
            {3'd5, 7'd31}: ch = 7'h30;
            default:       ch = '0;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/mtd_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtd_core
// Sample register, run timing, symbol collection and character decode.
// ----------------------------------------------------------------------------
module mtd_core #(
    parameter int MAX_SYMBOLS      = 7,
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mtd_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mtd_pkg::LEVEL_W-1:0]   in_sample,
    input  logic                          pair_ready,
    output logic                          pair_valid,
    output mtd_pkg::result_pair_t         pair
);
    import mtd_pkg::*;

    localparam int LEN_W = $clog2(MAX_SYMBOLS + 2);
    localparam int CMP_W = (TICK_COUNT_WIDTH > CFG_TICK_W) ? TICK_COUNT_WIDTH : CFG_TICK_W;

    logic                        in_valid_reg;
    logic [LEVEL_W-1:0]          sample_reg;
    logic                        signal_on_reg, signal_on_next;
    logic [TICK_COUNT_WIDTH-1:0] run_ticks_reg, run_ticks_next;
    logic                        gap_active_reg, gap_active_next;
    logic [PATTERN_BITS-1:0]     pattern_reg, pattern_next;
    logic [LEN_W-1:0]            length_reg, length_next;

    logic                    advance;
    logic                    on;
    logic                    toggled;
    logic [CMP_W-1:0]        finished;
    logic [CMP_W-1:0]        run_a;
    logic [TICK_COUNT_WIDTH-1:0] run_sum;
    logic                    gap_a;
    logic [PATTERN_BITS-1:0] pat_a;
    logic [LEN_W-1:0]        len_a;
    logic                    add_sym;
    logic                    add_dash;
    logic                    do_flush;
    logic                    do_word;
    logic                    flush_char;
    logic [CHAR_W-1:0]       table_char;
    logic                    unknown;
    result_t                 char_res;
    result_t                 word_res;

    assign advance  = in_valid_reg && pair_ready;
    assign in_ready = !in_valid_reg || pair_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sample_reg <= in_sample;
        end
    end

    always_comb begin
        on       = sample_reg > cfg.level_threshold;
        toggled  = on != signal_on_reg;
        finished = CMP_W'(run_ticks_reg);
        run_sum  = (run_ticks_reg != '1) ? run_ticks_reg + 1'b1 : run_ticks_reg;
        run_a    = toggled ? CMP_W'(1) : CMP_W'(run_sum);

        add_sym  = 1'b0;
        add_dash = 1'b0;
        if (toggled && !on) begin
            if (finished < CMP_W'(cfg.dot_limit_ticks)) begin
                add_sym = 1'b1;
            end else if (finished < CMP_W'(cfg.dash_limit_ticks)) begin
                add_sym  = 1'b1;
                add_dash = 1'b1;
            end
        end

        pat_a = pattern_reg;
        len_a = length_reg;
        if (add_sym && (length_reg <= LEN_W'(MAX_SYMBOLS))) begin
            if (add_dash && (length_reg < LEN_W'(PATTERN_BITS))) begin
                pat_a[length_reg[2:0]] = 1'b1;
            end
            len_a = length_reg + 1'b1;
        end

        gap_a = toggled ? !on : gap_active_reg;

        do_flush = 1'b0;
        do_word  = 1'b0;
        if (on) begin
            if (toggled && gap_active_reg) begin
                do_word  = finished >= CMP_W'(cfg.word_gap_ticks);
                do_flush = do_word || (finished >= CMP_W'(cfg.symbol_gap_ticks));
            end
        end else begin
            do_word  = gap_a && (run_a >= CMP_W'(cfg.word_gap_ticks));
            do_flush = do_word;
        end
        flush_char = do_flush && (len_a != '0);

        table_char = (len_a <= LEN_W'(TABLE_MAX_LEN))
                   ? morse_lookup(len_a[TABLE_LEN_W-1:0], pat_a) : '0;
        unknown    = (len_a > LEN_W'(MAX_SYMBOLS)) || (table_char == '0);

        char_res.kind     = unknown ? KIND_UNKNOWN : KIND_CHAR;
        char_res.char_out = unknown ? '0 : table_char;
        char_res.last     = !do_word;
        word_res.kind     = KIND_WORD_END;
        word_res.char_out = '0;
        word_res.last     = 1'b1;

        pair_valid = advance && (flush_char || do_word);
        pair.r0    = flush_char ? char_res : word_res;
        pair.r1    = word_res;

        signal_on_next  = on;
        run_ticks_next  = run_a[TICK_COUNT_WIDTH-1:0];
        gap_active_next = gap_a && !do_word;
        pattern_next    = do_flush ? '0 : pat_a;
        length_next     = do_flush ? '0 : len_a;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signal_on_reg  <= 1'b0;
            run_ticks_reg  <= '0;
            gap_active_reg <= 1'b0;
            pattern_reg    <= '0;
            length_reg     <= '0;
        end else if (advance) begin
            signal_on_reg  <= signal_on_next;
            run_ticks_reg  <= run_ticks_next;
            gap_active_reg <= gap_active_next;
            pattern_reg    <= pattern_next;
            length_reg     <= length_next;
        end
    end

endmodule

// ----- rtl/mtd_result_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtd_result_queue
// Two-slot queue of result pairs, unloaded one result per transaction.
// ----------------------------------------------------------------------------
module mtd_result_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  pair_valid,
    output logic                  pair_ready,
    input  mtd_pkg::result_pair_t pair,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mtd_pkg::result_t      out_result
);
    import mtd_pkg::*;

    result_pair_t slot_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic         sub_reg;
    logic [1:0]   count_reg;
    logic         push;
    logic         pop_item;
    logic         pop_pair;

    assign pair_ready = count_reg != 2'd2;
    assign push       = pair_valid && pair_ready;
    assign out_valid  = count_reg != 2'd0;
    assign out_result = sub_reg ? slot_reg[rd_ptr_reg].r1 : slot_reg[rd_ptr_reg].r0;
    assign pop_item   = out_valid && out_ready;
    assign pop_pair   = pop_item && out_result.last;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= pair;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            sub_reg    <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop_pair) begin
                rd_ptr_reg <= !rd_ptr_reg;
                sub_reg    <= 1'b0;
            end else if (pop_item) begin
                sub_reg <= 1'b1;
            end
            if (push && !pop_pair) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop_pair && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ----- rtl/morse_timing_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_timing_decoder_unit
// Morse decoder: thresholds samples, times marks and gaps, emits characters.
// Each sample is registered, decoded and its results queued (two-pair queue).
// Throughput: one sample per cycle while the result queue has room; a sample
// yielding a character and a word end holds the output for two transactions.
// Reset: synchronous, active low; clears timing and code state, restores
// register defaults.
// ----------------------------------------------------------------------------
module morse_timing_decoder_unit #(
    parameter int MAX_SYMBOLS      = 7,
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mtd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mtd_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mtd_pkg::S_TDATA_W-1:0]     s_tdata,   // [11:0] sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mtd_pkg::M_TDATA_W-1:0]     m_tdata,   // [6:0] char_out
    output logic [mtd_pkg::KIND_W-1:0]        m_tuser,   // [1:0] kind
    output logic                              m_tlast
);
    import mtd_pkg::*;

    cfg_t         cfg_reg;
    logic         pair_valid;
    logic         pair_ready;
    result_pair_t pair;
    result_t      out_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.level_threshold  <= LEVEL_THRESHOLD_RST;
            cfg_reg.dot_limit_ticks  <= DOT_LIMIT_TICKS_RST;
            cfg_reg.dash_limit_ticks <= DASH_LIMIT_TICKS_RST;
            cfg_reg.symbol_gap_ticks <= SYMBOL_GAP_TICKS_RST;
            cfg_reg.word_gap_ticks   <= WORD_GAP_TICKS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LEVEL_THRESHOLD:  cfg_reg.level_threshold  <= cfg_wr_data[LEVEL_W-1:0];
                REG_DOT_LIMIT_TICKS:  cfg_reg.dot_limit_ticks  <= cfg_wr_data;
                REG_DASH_LIMIT_TICKS: cfg_reg.dash_limit_ticks <= cfg_wr_data;
                REG_SYMBOL_GAP_TICKS: cfg_reg.symbol_gap_ticks <= cfg_wr_data;
                REG_WORD_GAP_TICKS:   cfg_reg.word_gap_ticks   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    mtd_core #(
        .MAX_SYMBOLS      (MAX_SYMBOLS),
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  (s_tdata[LEVEL_W-1:0]),
        .pair_ready (pair_ready),
        .pair_valid (pair_valid),
        .pair       (pair)
    );

    mtd_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair       (pair),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {{(M_TDATA_W - CHAR_W){1'b0}}, out_result.char_out};
    assign m_tuser = out_result.kind;
    assign m_tlast = out_result.last;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for morse_timing_decoder_unit. Sample transactions are
// streamed in while an in-bench Morse timing decoder predicts each result.
// Every result transaction is compared field by field in arrival order.
// A short directed walk runs first, then random keyed characters and noise
// under several register settings, idle patterns and one long output stall.
// ----------------------------------------------------------------------------
module testbench;

    import mtd_pkg::*;

    localparam int unsigned RUN_CAP     = 65535;
    localparam int unsigned SYMBOL_CAP  = 7;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES = 400;

    typedef struct {
        cfg_t        regs;
        int unsigned src_pct;
        int unsigned snk_pct;
        int unsigned items;
        bit          squeeze;
    } phase_t;

    typedef struct {
        logic [LEVEL_W-1:0] smp;
        int                 typed_n;
        result_t            r0;
        result_t            r1;
    } probe_t;

    localparam result_t NO_RES = '0;

    logic                   aclk;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   m_tlast;

    string morse_codes[36] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..", ".----", "..---", "...--",
        "....-", ".....", "-....", "--...", "---..", "----.", "-----"
    };
    string morse_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890";

    // decoder model state
    cfg_t              dec_cfg;
    bit                sig_on      = 1'b0;
    int unsigned       run_len     = 0;
    bit                gap_live    = 1'b0;
    logic [6:0]        code_bits   = '0;
    int unsigned       code_cnt    = 0;
    result_t           tick_out[$];
    result_t           pending_decodes[$];
    result_t           head_result;

    int unsigned       src_idle_pct   = 0;
    int unsigned       sink_stall_pct = 0;
    logic              hold_on        = 1'b0;
    event              hold_kick;
    int unsigned       samples_fed    = 0;
    int unsigned       results_seen   = 0;
    int unsigned       seen_chars     = 0;
    int unsigned       seen_unknown   = 0;
    int unsigned       seen_word_ends = 0;
    int unsigned       errors         = 0;
    int unsigned       quiet_cycles   = 0;

    probe_t probe_rows[20] = '{
        '{12'd0,    -1, NO_RES, NO_RES},
        '{12'd0,    -1, NO_RES, NO_RES},
        '{12'd4095, 0,  NO_RES, NO_RES},
        '{12'd0,    -1, NO_RES, NO_RES},
        '{12'd4095, -1, NO_RES, NO_RES},
        '{12'd4095, -1, NO_RES, NO_RES},
        '{12'd200,  -1, NO_RES, NO_RES},
        '{12'd0,    -1, NO_RES, NO_RES},
        '{12'd201,  1,  '{KIND_CHAR, 7'h41, 1'b1}, NO_RES},
        '{12'd201,  -1, NO_RES, NO_RES},
        '{12'd4095, -1, NO_RES, NO_RES},
        '{12'd0,    0,  NO_RES, NO_RES},
        '{12'd0,    -1, NO_RES, NO_RES},
        '{12'd4095, 0,  NO_RES, NO_RES},
        '{12'd0,    -1, NO_RES, NO_RES},
        '{12'd0,    -1, NO_RES, NO_RES},
        '{12'd0,    2,  '{KIND_CHAR, 7'h45, 1'b0}, '{KIND_WORD_END, 7'h00, 1'b1}},
        '{12'd0,    0,  NO_RES, NO_RES},
        '{12'd4095, -1, NO_RES, NO_RES},
        '{12'd0,    -1, NO_RES, NO_RES}
    };

    phase_t phase_plan[7] = '{
        '{'{12'd2048, 16'd3, 16'd6, 16'd3, 16'd8},  0,  0,  300, 1'b1},
        '{'{12'd200,  16'd2, 16'd5, 16'd2, 16'd6},  50, 0,  300, 1'b0},
        '{'{12'd1000, 16'd4, 16'd8, 16'd4, 16'd12}, 0,  50, 300, 1'b0},
        '{'{12'd3000, 16'd1, 16'd3, 16'd1, 16'd5},  24, 24, 230, 1'b0},
        '{'{12'd0,    16'd2, 16'd4, 16'd2, 16'd1},  0,  0,  60,  1'b0},
        '{'{12'd200,  16'd0, 16'd3, 16'd0, 16'd4},  24, 24, 80,  1'b0},
        '{'{12'd4095, 16'd3, 16'd6, 16'd3, 16'd8},  50, 50, 40,  1'b0}
    };

    morse_timing_decoder_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [6:0] morse_char(int unsigned len, logic [6:0] pat);
        logic [6:0] sym_bits;
        logic [7:0] ascii;
        for (int i = 0; i < 36; i++) begin
            sym_bits = '0;
            for (int j = 0; j < morse_codes[i].len(); j++) begin
                if (morse_codes[i][j] == "-") sym_bits[j] = 1'b1;
            end
            if (morse_codes[i].len() == len && sym_bits == pat) begin
                ascii = morse_alpha[i];
                return ascii[6:0];
            end
        end
        return 7'd0;
    endfunction

    function automatic void emit(logic [KIND_W-1:0] k, logic [CHAR_W-1:0] ch);
        result_t r;
        r.kind     = k;
        r.char_out = ch;
        r.last     = 1'b0;
        tick_out.push_back(r);
    endfunction

    function automatic void close_code();
        logic [6:0] ch;
        if (code_cnt == 0) return;
        ch = (code_cnt > SYMBOL_CAP) ? 7'd0 : morse_char(code_cnt, code_bits);
        if (ch != 7'd0) emit(KIND_CHAR, ch);
        else emit(KIND_UNKNOWN, 7'd0);
        code_cnt  = 0;
        code_bits = '0;
    endfunction

    function automatic void add_mark(bit dash);
        if (code_cnt > SYMBOL_CAP) return;
        if (code_cnt < PATTERN_BITS && dash) code_bits[code_cnt] = 1'b1;
        code_cnt++;
    endfunction

    function automatic void decode_tick(logic [LEVEL_W-1:0] smp);
        bit          level_on;
        int unsigned done_len;
        result_t     r;
        tick_out.delete();
        level_on = smp > dec_cfg.level_threshold;
        if (level_on != sig_on) begin
            done_len = run_len;
            if (level_on) begin
                if (gap_live) begin
                    if (done_len >= dec_cfg.word_gap_ticks) begin
                        close_code();
                        emit(KIND_WORD_END, 7'd0);
                    end else if (done_len >= dec_cfg.symbol_gap_ticks) begin
                        close_code();
                    end
                end
                gap_live = 1'b0;
            end else begin
                if (done_len < dec_cfg.dot_limit_ticks) add_mark(1'b0);
                else if (done_len < dec_cfg.dash_limit_ticks) add_mark(1'b1);
                gap_live = 1'b1;
            end
            sig_on  = level_on;
            run_len = 1;
        end else if (run_len < RUN_CAP) begin
            run_len++;
        end
        if (!level_on && gap_live && run_len >= dec_cfg.word_gap_ticks) begin
            close_code();
            emit(KIND_WORD_END, 7'd0);
            gap_live = 1'b0;
        end
        if (tick_out.size() != 0) begin
            r = tick_out.pop_back();
            r.last = 1'b1;
            tick_out.push_back(r);
        end
    endfunction

    function automatic int unsigned span(int unsigned lo, int unsigned hi);
        return (hi <= lo) ? lo : $urandom_range(hi, lo);
    endfunction

    function automatic logic [LEVEL_W-1:0] mark_level();
        if (dec_cfg.level_threshold == 12'hFFF) return 12'hFFF;
        return 12'($urandom_range(4095, dec_cfg.level_threshold + 1));
    endfunction

    function automatic logic [LEVEL_W-1:0] space_level();
        return 12'($urandom_range(dec_cfg.level_threshold, 0));
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic offer_sample(logic [LEVEL_W-1:0] smp);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, smp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        samples_fed++;
    endtask

    task automatic feed(logic [LEVEL_W-1:0] smp);
        offer_sample(smp);
        decode_tick(smp);
        foreach (tick_out[i]) pending_decodes.push_back(tick_out[i]);
    endtask

    task automatic hold_level(bit mark, int unsigned ticks);
        repeat (ticks) feed(mark ? mark_level() : space_level());
    endtask

    task automatic send_symbol(bit dash);
        int unsigned dot;
        int unsigned dsh;
        int unsigned len;
        dot = dec_cfg.dot_limit_ticks;
        dsh = dec_cfg.dash_limit_ticks;
        if ((dash || dot <= 1) && dsh > dot && dsh > 1)
            len = span((dot == 0) ? 1 : dot, dsh - 1);
        else
            len = (dot > 1) ? span(1, dot - 1) : 1;
        hold_level(1'b1, len);
    endtask

    task automatic send_char();
        int unsigned n;
        int unsigned sym;
        int unsigned wrd;
        int unsigned pick;
        logic [8:0]  pat;
        string       code;
        sym = dec_cfg.symbol_gap_ticks;
        wrd = dec_cfg.word_gap_ticks;
        pat = '0;
        if ($urandom_range(9) < 8) begin
            code = morse_codes[$urandom_range(35)];
            n    = code.len();
            for (int j = 0; j < n; j++) pat[j] = (code[j] == "-");
        end else begin
            n   = $urandom_range(9, 1);
            pat = 9'($urandom);
        end
        for (int j = 0; j < n; j++) begin
            send_symbol(pat[j]);
            if (j + 1 < n) hold_level(1'b0, (sym > 1) ? span(1, sym - 1) : 1);
        end
        pick = $urandom_range(99);
        if (pick < 60)
            hold_level(1'b0, span((sym == 0) ? 1 : sym, (wrd > 1) ? wrd - 1 : 1));
        else if (pick < 85)
            hold_level(1'b0, span(wrd, wrd + 3));
        else
            hold_level(1'b0, (sym > 1) ? span(1, sym - 1) : 1);
    endtask

    task automatic random_traffic(int unsigned n);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = samples_fed + n;
        while (samples_fed < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 75)
                send_char();
            else if (pick < 85)
                repeat ($urandom_range(8, 1)) feed(12'($urandom));
            else if (pick < 93)
                hold_level(1'b1, span(dec_cfg.dash_limit_ticks, dec_cfg.dash_limit_ticks + 4));
            else
                hold_level(1'b0, span(dec_cfg.word_gap_ticks, dec_cfg.word_gap_ticks + 6));
        end
    endtask

    task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
    endtask

    task automatic load_regs(cfg_t c);
        put_reg(REG_LEVEL_THRESHOLD, 16'(c.level_threshold));
        put_reg(REG_DOT_LIMIT_TICKS, c.dot_limit_ticks);
        put_reg(REG_DASH_LIMIT_TICKS, c.dash_limit_ticks);
        put_reg(REG_SYMBOL_GAP_TICKS, c.symbol_gap_ticks);
        put_reg(REG_WORD_GAP_TICKS, c.word_gap_ticks);
        cfg_wr_en <= 1'b0;
        dec_cfg = c;
    endtask

    task automatic drain(int unsigned tail);
        s_tvalid <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    // output side: random backpressure, forced low during a hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_on && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        forever begin
            @(hold_kick);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_on <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_decodes.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d char %02h last %0d",
                                          m_tuser, m_tdata[CHAR_W-1:0], m_tlast));
            end else begin
                head_result = pending_decodes.pop_front();
                results_seen++;
                if (head_result.kind == KIND_CHAR) seen_chars++;
                else if (head_result.kind == KIND_UNKNOWN) seen_unknown++;
                else seen_word_ends++;
                if (m_tuser !== head_result.kind)
                    report_mismatch($sformatf("result %0d kind %0d, want %0d",
                                              results_seen, m_tuser, head_result.kind));
                if (m_tdata[CHAR_W-1:0] !== head_result.char_out)
                    report_mismatch($sformatf("result %0d char %02h, want %02h", results_seen,
                                              m_tdata[CHAR_W-1:0], head_result.char_out));
                if (m_tlast !== head_result.last)
                    report_mismatch($sformatf("result %0d last %0d, want %0d",
                                              results_seen, m_tlast, head_result.last));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[%0t] timeout with %0d results outstanding", $time,
                         pending_decodes.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        dec_cfg = '{LEVEL_THRESHOLD_RST, DOT_LIMIT_TICKS_RST, DASH_LIMIT_TICKS_RST,
                    SYMBOL_GAP_TICKS_RST, WORD_GAP_TICKS_RST};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_regs('{12'd200, 16'd2, 16'd3, 16'd2, 16'd3});
        foreach (probe_rows[i]) begin
            offer_sample(probe_rows[i].smp);
            decode_tick(probe_rows[i].smp);
            if (probe_rows[i].typed_n < 0) begin
                foreach (tick_out[k]) pending_decodes.push_back(tick_out[k]);
            end else begin
                if (probe_rows[i].typed_n > 0) pending_decodes.push_back(probe_rows[i].r0);
                if (probe_rows[i].typed_n > 1) pending_decodes.push_back(probe_rows[i].r1);
            end
        end

        foreach (phase_plan[p]) begin
            drain(8);
            src_idle_pct   = phase_plan[p].src_pct;
            sink_stall_pct = phase_plan[p].snk_pct;
            load_regs(phase_plan[p].regs);
            if (phase_plan[p].squeeze) -> hold_kick;
            random_traffic(phase_plan[p].items);
        end

        drain(20);
        $display("Run fed %0d samples under 8 register settings and checked %0d results",
                 samples_fed, results_seen);
        $display("(%0d characters, %0d unknown codes, %0d word ends), with idle and stalls.",
                 seen_chars, seen_unknown, seen_word_ends);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mtd_pkg.sv
rtl/mtd_core.sv
rtl/mtd_result_queue.sv
rtl/morse_timing_decoder_unit.sv
tb/testbench.sv
